### rtl/swst_pkg.sv
// Package for the sensor window statistics block: sizes, register indexes,
// trend codes, sequencer states and the ring control struct. No dependencies.
`timescale 1ns / 1ps
`default_nettype none

package swst_pkg;

   localparam int WINDOW   = 10;
   localparam int SAMPLE_W = 16;
   localparam int SUM_W    = SAMPLE_W + $clog2(WINDOW);
   localparam int CNT_W    = $clog2(WINDOW + 1);
   localparam int SLOT_W   = (WINDOW > 1) ? $clog2(WINDOW) : 1;
   localparam int STEP_W   = $clog2(SUM_W + 1);
   localparam int DBAND_W  = 10;
   localparam int CSR_IDX_W = 2;

   localparam logic [CSR_IDX_W-1:0] CSR_NORMAL_LOW     = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_NORMAL_HIGH    = 2'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_TREND_DEADBAND = 2'd2;

   localparam logic signed [SAMPLE_W-1:0] NORMAL_LOW_RST  = 16'sd2300;
   localparam logic signed [SAMPLE_W-1:0] NORMAL_HIGH_RST = 16'sd2700;
   localparam logic [DBAND_W-1:0]         DEADBAND_RST    = 10'd1;

   typedef enum logic [1:0] {
      TREND_STABLE  = 2'd0,
      TREND_RISING  = 2'd1,
      TREND_FALLING = 2'd2
   } trend_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_READ,
      ST_UPDATE,
      ST_START,
      ST_DIVIDE,
      ST_FINISH
   } state_type;

   typedef struct packed {
      logic rd_en;   // fetch the entry about to be overwritten
      logic upd;     // commit the new sample
   } ring_ctrl_type;

endpackage

`default_nettype wire

### rtl/swst_ring.sv
// Sample ring with write slot, fill count and running sum.
// Depends on swst_pkg.
`timescale 1ns / 1ps
`default_nettype none

module swst_ring
   import swst_pkg::*;
(
   input  wire logic                       clock,
   input  wire logic                       reset,
   input  wire ring_ctrl_type              ctrl,
   input  wire logic signed [SAMPLE_W-1:0] sample,
   output logic signed [SUM_W-1:0]         sum,
   output logic [CNT_W-1:0]                count
);

   logic signed [SAMPLE_W-1:0] mem [WINDOW];
   logic signed [SAMPLE_W-1:0] old_ff;
   logic [SLOT_W-1:0]          slot_ff, slot_in;
   logic [CNT_W-1:0]           count_ff, count_in;
   logic signed [SUM_W-1:0]    sum_ff, sum_in;
   logic                       full;

   assign full = (count_ff == CNT_W'(WINDOW));

   always_ff @(posedge clock) begin
      if (ctrl.rd_en) begin
         old_ff <= mem[slot_ff];
      end
      if (ctrl.upd) begin
         mem[slot_ff] <= sample;
      end
   end

   always_comb begin
      slot_in  = slot_ff;
      count_in = count_ff;
      sum_in   = sum_ff;
      if (ctrl.upd) begin
         slot_in = (slot_ff == SLOT_W'(WINDOW - 1)) ? '0 : slot_ff + 1'b1;
         if (full) begin
            sum_in = sum_ff + SUM_W'(sample) - SUM_W'(old_ff);
         end else begin
            sum_in   = sum_ff + SUM_W'(sample);
            count_in = count_ff + 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         slot_ff  <= '0;
         count_ff <= '0;
         sum_ff   <= '0;
      end else begin
         slot_ff  <= slot_in;
         count_ff <= count_in;
         sum_ff   <= sum_in;
      end
   end

   assign sum   = sum_ff;
   assign count = count_ff;

endmodule

`default_nettype wire

### rtl/swst_div.sv
// Bit-serial restoring divider: unsigned dividend by the fill count, one
// quotient bit per cycle. Depends on swst_pkg.
`timescale 1ns / 1ps
`default_nettype none

module swst_div
   import swst_pkg::*;
(
   input  wire logic               clock,
   input  wire logic               reset,
   input  wire logic               start,
   input  wire logic [SUM_W-1:0]   dividend,
   input  wire logic [CNT_W-1:0]   divisor,
   output logic                    busy,
   output logic [SUM_W-1:0]        quotient
);

   logic [SUM_W-1:0]  dq_ff, dq_in;     // dividend bits out at top, quotient in at bottom
   logic [CNT_W-1:0]  rem_ff, rem_in;
   logic [CNT_W-1:0]  dvs_ff;
   logic [STEP_W-1:0] step_ff, step_in;
   logic              busy_ff, busy_in;
   logic [CNT_W:0]    trial, diff;
   logic              ge;

   always_comb begin
      trial   = {rem_ff, dq_ff[SUM_W-1]};
      ge      = (trial >= {1'b0, dvs_ff});
      diff    = trial - {1'b0, dvs_ff};
      dq_in   = dq_ff;
      rem_in  = rem_ff;
      step_in = step_ff;
      busy_in = busy_ff;
      if (start) begin
         dq_in   = dividend;
         rem_in  = '0;
         step_in = STEP_W'(SUM_W);
         busy_in = 1'b1;
      end else if (busy_ff) begin
         dq_in   = {dq_ff[SUM_W-2:0], ge};
         rem_in  = ge ? diff[CNT_W-1:0] : trial[CNT_W-1:0];
         step_in = step_ff - 1'b1;
         busy_in = (step_ff != STEP_W'(1));
      end
   end

   always_ff @(posedge clock) begin
      dq_ff  <= dq_in;
      rem_ff <= rem_in;
      if (start) begin
         dvs_ff <= divisor;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         step_ff <= '0;
      end else begin
         busy_ff <= busy_in;
         step_ff <= step_in;
      end
   end

   assign busy     = busy_ff;
   assign quotient = dq_ff;

endmodule

`default_nettype wire

### rtl/sensor_window_statistics_core.sv
// Top level: sequencer, min/max, trend and band checks, result register.
// Depends on swst_pkg, swst_ring and swst_div.
//
//   port group  dir  handshake          words
//   req_*       in   req_valid/ready    sample
//   rsp_*       out  rsp_valid/ready    window_mean, lowest, highest, trend, out_of_band
//   csr_*       in   csr_we             normal_low, normal_high, trend_deadband
//
// One word goes through READ (fetch the entry about to be overwritten),
// UPDATE (commit the sample), START, DIVIDE (the serial divider, one quotient
// bit per cycle) and FINISH; a new word is taken only in IDLE, after FINISH.
// Reset clears the sequencer, sum, count, slot, min/max, previous sample and
// rsp_valid; ring entries are not cleared. A finished result waits in the output
// register while the next word is taken; the sequencer stalls only if it is still full.
`timescale 1ns / 1ps
`default_nettype none

module sensor_window_statistics_core
   import swst_pkg::*;
(
   input  wire logic                       clock,
   input  wire logic                       reset,
   input  wire logic                       req_valid,
   output logic                            req_ready,
   input  wire logic signed [SAMPLE_W-1:0] req_sample,
   output logic                            rsp_valid,
   input  wire logic                       rsp_ready,
   output logic signed [SAMPLE_W-1:0]      rsp_window_mean,
   output logic signed [SAMPLE_W-1:0]      rsp_lowest,
   output logic signed [SAMPLE_W-1:0]      rsp_highest,
   output logic [1:0]                      rsp_trend,
   output logic                            rsp_out_of_band,
   input  wire logic                       csr_we,
   input  wire logic [CSR_IDX_W-1:0]       csr_index,
   input  wire logic [SAMPLE_W-1:0]        csr_wdata
);

   state_type state_ff, state_in;
   ring_ctrl_type ring_ctrl;

   logic signed [SAMPLE_W-1:0] normal_low_ff, normal_high_ff;
   logic [DBAND_W-1:0]         deadband_ff;

   logic signed [SAMPLE_W-1:0] sample_ff;
   logic signed [SAMPLE_W-1:0] min_ff, max_ff, prev_ff;
   trend_type                  trend_ff, trend_in;
   logic                       oob_ff;
   logic                       neg_ff;

   logic signed [SUM_W-1:0]    ring_sum;
   logic [CNT_W-1:0]           ring_count;
   logic [SUM_W-1:0]           sum_mag;
   logic                       div_start, div_busy;
   logic [SUM_W-1:0]           div_q;
   logic [SAMPLE_W-1:0]        mean_mag;

   logic                       rsp_valid_ff;
   logic signed [SAMPLE_W-1:0] mean_out_ff, low_out_ff, high_out_ff;
   logic [1:0]                 trend_out_ff;
   logic                       oob_out_ff;

   logic                       accept, load_out, first;
   logic signed [SAMPLE_W:0]   diff;
   logic [SAMPLE_W:0]          mag;

   swst_ring u_ring (
      .clock  (clock),
      .reset  (reset),
      .ctrl   (ring_ctrl),
      .sample (sample_ff),
      .sum    (ring_sum),
      .count  (ring_count)
   );

   assign sum_mag = ring_sum[SUM_W-1] ? SUM_W'(-ring_sum) : SUM_W'(ring_sum);

   swst_div u_div (
      .clock    (clock),
      .reset    (reset),
      .start    (div_start),
      .dividend (sum_mag),
      .divisor  (ring_count),
      .busy     (div_busy),
      .quotient (div_q)
   );

   // csr
   always_ff @(posedge clock) begin
      if (reset) begin
         normal_low_ff  <= NORMAL_LOW_RST;
         normal_high_ff <= NORMAL_HIGH_RST;
         deadband_ff    <= DEADBAND_RST;
      end else if (csr_we) begin
         case (csr_index)
            CSR_NORMAL_LOW:     normal_low_ff  <= csr_wdata;
            CSR_NORMAL_HIGH:    normal_high_ff <= csr_wdata;
            CSR_TREND_DEADBAND: deadband_ff    <= csr_wdata[DBAND_W-1:0];
            default: ;
         endcase
      end
   end

   // sequencer
   always_comb begin
      state_in      = state_ff;
      req_ready     = 1'b0;
      ring_ctrl     = '0;
      div_start     = 1'b0;
      load_out      = 1'b0;
      case (state_ff)
         ST_IDLE: begin
            req_ready = 1'b1;
            if (req_valid) state_in = ST_READ;
         end
         ST_READ: begin
            ring_ctrl.rd_en = 1'b1;
            state_in        = ST_UPDATE;
         end
         ST_UPDATE: begin
            ring_ctrl.upd = 1'b1;
            state_in      = ST_START;
         end
         ST_START: begin
            div_start = 1'b1;
            state_in  = ST_DIVIDE;
         end
         ST_DIVIDE: begin
            if (!div_busy) state_in = ST_FINISH;
         end
         ST_FINISH: begin
            if (!rsp_valid_ff || rsp_ready) begin
               load_out = 1'b1;
               state_in = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   assign accept = req_valid && req_ready;
   assign first  = (ring_count == '0);

   always_comb begin
      diff = {sample_ff[SAMPLE_W-1], sample_ff} - {prev_ff[SAMPLE_W-1], prev_ff};
      mag  = diff[SAMPLE_W] ? (SAMPLE_W + 1)'(-diff) : diff;
      // zero deadband: a zero difference falls through to falling
      if (first || (mag < (SAMPLE_W + 1)'(deadband_ff))) begin
         trend_in = TREND_STABLE;
      end else if (!diff[SAMPLE_W] && (diff != '0)) begin
         trend_in = TREND_RISING;
      end else begin
         trend_in = TREND_FALLING;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
         min_ff       <= '0;
         max_ff       <= '0;
         prev_ff      <= '0;
      end else begin
         state_ff <= state_in;
         if (load_out) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_ready) begin
            rsp_valid_ff <= 1'b0;
         end
         if (ring_ctrl.upd) begin
            prev_ff <= sample_ff;
            if (first || (sample_ff < min_ff)) min_ff <= sample_ff;
            if (first || (sample_ff > max_ff)) max_ff <= sample_ff;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         sample_ff <= req_sample;
      end
      if (ring_ctrl.upd) begin
         trend_ff <= trend_in;
         oob_ff   <= (sample_ff < normal_low_ff) || (sample_ff > normal_high_ff);
      end
      if (div_start) begin
         neg_ff <= ring_sum[SUM_W-1];
      end
   end

   assign mean_mag = div_q[SAMPLE_W-1:0];

   always_ff @(posedge clock) begin
      if (load_out) begin
         mean_out_ff  <= neg_ff ? -mean_mag : mean_mag;
         low_out_ff   <= min_ff;
         high_out_ff  <= max_ff;
         trend_out_ff <= trend_ff;
         oob_out_ff   <= oob_ff;
      end
   end

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_window_mean = mean_out_ff;
   assign rsp_lowest      = low_out_ff;
   assign rsp_highest     = high_out_ff;
   assign rsp_trend       = trend_out_ff;
   assign rsp_out_of_band = oob_out_ff;

endmodule

`default_nettype wire
